// ===== rtl/ccp_pkg.sv =====
// shared types and constants for the cyclotomic coset partition block
// used by every module under rtl; depends on nothing
package ccp_pkg;

    localparam int MAX_MODULUS = 1024;
    localparam int MAX_DEGREE  = 10;
    localparam int ELEM_W      = 10;
    localparam int COSET_W     = 9;
    localparam int POS_W       = 4;
    localparam int TOTAL_W     = 10;
    localparam int MOD_W       = 11;
    localparam int BASE_W      = 5;
    localparam int DEG_W       = 4;
    localparam int QDEPTH      = 2;
    localparam int QPTR_W      = $clog2(QDEPTH);

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_RANGE = 2'd1;
    localparam logic [1:0] STATUS_CAP   = 2'd2;

    localparam logic REG_FIELD_BASE = 1'b0;
    localparam logic REG_EXT_DEGREE = 1'b1;

    typedef enum logic [1:0] {
        CMD_ERR_CAP,
        CMD_ERR_RANGE,
        CMD_LOOKUP,
        CMD_LIST
    } cmd_kind_t;

    typedef struct packed {
        logic                 operation;
        logic [ELEM_W-1:0]    query_element;
        logic [COSET_W-1:0]   query_coset;
    } in_item_t;

    typedef struct packed {
        logic [COSET_W-1:0]   coset_id;
        logic [ELEM_W-1:0]    member_value;
        logic [POS_W-1:0]     member_position;
        logic [POS_W-1:0]     coset_length;
        logic [TOTAL_W-1:0]   coset_total;
        logic                 last_member;
        logic [1:0]           status;
    } res_t;

    typedef struct packed {
        cmd_kind_t            kind;
        logic [ELEM_W-1:0]    elem;
        logic [COSET_W-1:0]   cidx;
        logic [COSET_W-1:0]   owner;
        logic [POS_W-1:0]     pos;
    } cmd_t;

    // table write ports driven by the builder
    typedef struct packed {
        logic                 ent_we;
        logic [ELEM_W-1:0]    ent_addr;
        logic [COSET_W-1:0]   ent_owner;
        logic [POS_W-1:0]     ent_pos;
        logic                 mem_we;
        logic [ELEM_W-1:0]    mem_addr;
        logic [ELEM_W-1:0]    mem_val;
        logic                 head_we;
        logic [COSET_W-1:0]   head_addr;
        logic [ELEM_W-1:0]    head_first;
        logic                 len_we;
        logic [COSET_W-1:0]   len_addr;
        logic [POS_W-1:0]     len_val;
    } tbl_wr_t;

    typedef struct packed {
        logic                 busy;
        logic [MOD_W-1:0]     modulus;
        logic [TOTAL_W-1:0]   total;
    } bld_stat_t;

endpackage

// ===== rtl/ccp_builder.sv =====
// partition builder: clears the used map, forms q^m-1, walks every coset
// depends on ccp_pkg; drives the table write ports of front and back
module ccp_builder (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [ccp_pkg::BASE_W-1:0] base,
    input  logic [ccp_pkg::DEG_W-1:0]  degree,
    output ccp_pkg::tbl_wr_t           wr,
    output ccp_pkg::bld_stat_t         stat
);
    import ccp_pkg::*;

    typedef enum logic [2:0] {
        B_CLEAR, B_POWER, B_SCAN, B_CHECK, B_WALK, B_MUL, B_IDLE
    } bstate_t;

    bstate_t            state_reg;
    logic [ELEM_W-1:0]  clr_reg;
    logic [MOD_W-1:0]   power_reg;
    logic [DEG_W-1:0]   k_reg;
    logic [MOD_W-1:0]   mod_reg;
    logic [MOD_W-1:0]   i_reg;
    logic [MOD_W-1:0]   slot_reg;
    logic [TOTAL_W-1:0] count_reg;
    logic [ELEM_W-1:0]  e_reg;
    logic [POS_W-1:0]   len_reg;
    logic [ELEM_W-1:0]  acc_reg;
    logic [BASE_W-1:0]  mcnt_reg;
    logic [TOTAL_W-1:0] total_reg;
    logic [MOD_W-1:0]   modulus_reg;

    logic               used_mem [MAX_MODULUS];
    logic               used_rd;
    logic               used_we;
    logic [ELEM_W-1:0]  used_waddr;
    logic               used_wval;

    logic [15:0]        prod;
    logic [MOD_W-1:0]   acc_sum;
    logic [MOD_W-1:0]   acc_mod;
    logic               mul_last;
    logic               cont;
    logic               bad_cfg;

    assign prod     = 16'(power_reg) * 16'(base);
    assign acc_sum  = {1'b0, acc_reg} + {1'b0, e_reg};
    assign acc_mod  = (acc_sum >= mod_reg) ? acc_sum - mod_reg : acc_sum;
    assign mul_last = (mcnt_reg == BASE_W'(1));
    assign cont     = ({1'b0, acc_mod[ELEM_W-1:0]} != i_reg)
                      && (MOD_W'(len_reg) < mod_reg)
                      && (slot_reg < MOD_W'(MAX_MODULUS));
    assign bad_cfg  = (base < BASE_W'(2)) || (degree == '0)
                      || (degree > DEG_W'(MAX_DEGREE));

    assign used_we    = (state_reg == B_CLEAR) || (state_reg == B_WALK);
    assign used_waddr = (state_reg == B_CLEAR) ? clr_reg : e_reg;
    assign used_wval  = (state_reg == B_WALK);

    always_ff @(posedge clk)
    begin
        if (used_we)
        begin
            used_mem[used_waddr] <= used_wval;
        end
        if (state_reg == B_SCAN)
        begin
            used_rd <= used_mem[i_reg[ELEM_W-1:0]];
        end
    end

    always_comb
    begin
        wr.ent_we     = (state_reg == B_WALK);
        wr.ent_addr   = e_reg;
        wr.ent_owner  = count_reg[COSET_W-1:0];
        wr.ent_pos    = len_reg;
        wr.mem_we     = (state_reg == B_WALK);
        wr.mem_addr   = slot_reg[ELEM_W-1:0];
        wr.mem_val    = e_reg;
        wr.head_we    = (state_reg == B_CHECK) && !used_rd;
        wr.head_addr  = count_reg[COSET_W-1:0];
        wr.head_first = slot_reg[ELEM_W-1:0];
        wr.len_we     = (state_reg == B_MUL) && mul_last && !cont;
        wr.len_addr   = count_reg[COSET_W-1:0];
        wr.len_val    = len_reg;
    end

    assign stat.busy    = (state_reg != B_IDLE);
    assign stat.modulus = modulus_reg;
    assign stat.total   = total_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= B_CLEAR;
            clr_reg     <= '0;
            total_reg   <= '0;
            modulus_reg <= '0;
            power_reg   <= '0;
            k_reg       <= '0;
            mod_reg     <= '0;
            i_reg       <= '0;
            slot_reg    <= '0;
            count_reg   <= '0;
            e_reg       <= '0;
            len_reg     <= '0;
            acc_reg     <= '0;
            mcnt_reg    <= '0;
        end
        else if (start)
        begin
            state_reg   <= B_CLEAR;
            clr_reg     <= '0;
            total_reg   <= '0;
            modulus_reg <= '0;
        end
        else
        begin
            unique case (state_reg)
                B_CLEAR:
                begin
                    clr_reg <= clr_reg + ELEM_W'(1);
                    if (clr_reg == ELEM_W'(MAX_MODULUS - 1))
                    begin
                        power_reg <= MOD_W'(1);
                        k_reg     <= '0;
                        state_reg <= bad_cfg ? B_IDLE : B_POWER;
                    end
                end
                B_POWER:
                begin
                    if (prod > 16'(MAX_MODULUS + 1))
                    begin
                        state_reg <= B_IDLE;
                    end
                    else
                    begin
                        power_reg <= prod[MOD_W-1:0];
                        k_reg     <= k_reg + DEG_W'(1);
                        if (k_reg + DEG_W'(1) == degree)
                        begin
                            mod_reg   <= prod[MOD_W-1:0] - MOD_W'(1);
                            i_reg     <= '0;
                            slot_reg  <= '0;
                            count_reg <= '0;
                            state_reg <= B_SCAN;
                        end
                    end
                end
                B_SCAN:
                begin
                    if (i_reg == mod_reg)
                    begin
                        total_reg   <= count_reg;
                        modulus_reg <= mod_reg;
                        state_reg   <= B_IDLE;
                    end
                    else
                    begin
                        state_reg <= B_CHECK;
                    end
                end
                B_CHECK:
                begin
                    if (used_rd)
                    begin
                        i_reg     <= i_reg + MOD_W'(1);
                        state_reg <= B_SCAN;
                    end
                    else
                    begin
                        e_reg     <= i_reg[ELEM_W-1:0];
                        len_reg   <= '0;
                        state_reg <= B_WALK;
                    end
                end
                B_WALK:
                begin
                    slot_reg  <= slot_reg + MOD_W'(1);
                    len_reg   <= len_reg + POS_W'(1);
                    acc_reg   <= '0;
                    mcnt_reg  <= base;
                    state_reg <= B_MUL;
                end
                B_MUL:
                begin
                    // q*e mod M by q modular additions
                    acc_reg  <= acc_mod[ELEM_W-1:0];
                    mcnt_reg <= mcnt_reg - BASE_W'(1);
                    if (mul_last)
                    begin
                        if (cont)
                        begin
                            e_reg     <= acc_mod[ELEM_W-1:0];
                            state_reg <= B_WALK;
                        end
                        else
                        begin
                            count_reg <= count_reg + TOTAL_W'(1);
                            i_reg     <= i_reg + MOD_W'(1);
                            state_reg <= B_SCAN;
                        end
                    end
                end
                B_IDLE:
                begin
                    state_reg <= B_IDLE;
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/ccp_front.sv =====
// front end: accepts items, classifies them, looks up owner and position
// depends on ccp_pkg; feeds the command queue
module ccp_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  ccp_pkg::in_item_t   item,
    input  ccp_pkg::bld_stat_t  stat,
    input  ccp_pkg::tbl_wr_t    wr,
    input  logic                q_full,
    output logic                q_push,
    output ccp_pkg::cmd_t       cmd
);
    import ccp_pkg::*;

    logic [COSET_W-1:0] owner_mem [MAX_MODULUS];
    logic [POS_W-1:0]   pos_mem   [MAX_MODULUS];
    logic [COSET_W-1:0] owner_rd;
    logic [POS_W-1:0]   pos_rd;

    logic               s1_valid_reg;
    cmd_kind_t          s1_kind_reg;
    logic [ELEM_W-1:0]  s1_elem_reg;
    logic [COSET_W-1:0] s1_cidx_reg;

    logic               accept;
    cmd_kind_t          kind_in;

    assign full   = stat.busy || (s1_valid_reg && q_full);
    assign accept = push && !full;
    assign q_push = s1_valid_reg && !q_full;

    always_comb
    begin
        if (stat.modulus == '0)
        begin
            kind_in = CMD_ERR_CAP;
        end
        else if (!item.operation)
        begin
            kind_in = (MOD_W'(item.query_element) >= stat.modulus) ? CMD_ERR_RANGE
                                                                    : CMD_LOOKUP;
        end
        else
        begin
            kind_in = (TOTAL_W'(item.query_coset) >= stat.total) ? CMD_ERR_RANGE
                                                                  : CMD_LIST;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.ent_we)
        begin
            owner_mem[wr.ent_addr] <= wr.ent_owner;
            pos_mem[wr.ent_addr]   <= wr.ent_pos;
        end
        if (accept)
        begin
            owner_rd <= owner_mem[item.query_element];
            pos_rd   <= pos_mem[item.query_element];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (q_push)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_kind_reg <= kind_in;
            s1_elem_reg <= item.query_element;
            s1_cidx_reg <= item.query_coset;
        end
    end

    always_comb
    begin
        cmd.kind  = s1_kind_reg;
        cmd.elem  = s1_elem_reg;
        cmd.cidx  = s1_cidx_reg;
        cmd.owner = owner_rd;
        cmd.pos   = pos_rd;
    end

endmodule

// ===== rtl/ccp_queue.sv =====
// short command queue between front and back
// depends on ccp_pkg for the command type and depth
module ccp_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  ccp_pkg::cmd_t  din,
    output logic           full,
    input  logic           pop,
    output ccp_pkg::cmd_t  dout,
    output logic           empty
);
    import ccp_pkg::*;

    cmd_t              slot_mem [QDEPTH];
    logic [QPTR_W-1:0] wp_reg;
    logic [QPTR_W-1:0] rp_reg;
    logic [QPTR_W:0]   cnt_reg;
    logic              do_push;
    logic              do_pop;

    assign full    = (cnt_reg == (QPTR_W+1)'(QDEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = slot_mem[rp_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_mem[wp_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wp_reg <= wp_reg + QPTR_W'(1);
            end
            if (do_pop)
            begin
                rp_reg <= rp_reg + QPTR_W'(1);
            end
            cnt_reg <= cnt_reg + (QPTR_W+1)'(do_push) - (QPTR_W+1)'(do_pop);
        end
    end

endmodule

// ===== rtl/ccp_back.sv =====
// back end: holds coset heads, lengths and member list, emits result beats
// depends on ccp_pkg; takes commands from the queue, owns the result queue
module ccp_back (
    input  logic                clk,
    input  logic                rst_n,
    input  ccp_pkg::cmd_t       cmd,
    input  logic                q_empty,
    output logic                q_pop,
    input  ccp_pkg::tbl_wr_t    wr,
    input  ccp_pkg::bld_stat_t  stat,
    output logic                empty,
    input  logic                pop,
    output ccp_pkg::res_t       result
);
    import ccp_pkg::*;

    typedef enum logic [1:0] { K_IDLE, K_LEN, K_HEAD, K_EMIT } kstate_t;

    logic [ELEM_W-1:0]  first_mem  [MAX_MODULUS/2];
    logic [POS_W-1:0]   len_mem    [MAX_MODULUS/2];
    logic [ELEM_W-1:0]  member_mem [MAX_MODULUS];
    logic [ELEM_W-1:0]  first_rd;
    logic [POS_W-1:0]   len_rd;
    logic [ELEM_W-1:0]  member_rd;

    kstate_t            state_reg;
    cmd_t               cmd_reg;
    logic [ELEM_W-1:0]  first_reg;
    logic [POS_W-1:0]   clen_reg;
    logic [POS_W-1:0]   j_reg;

    res_t               ofifo [QDEPTH];
    logic [QPTR_W-1:0]  owp_reg;
    logic [QPTR_W-1:0]  orp_reg;
    logic [QPTR_W:0]    ocnt_reg;
    logic               ofull;
    logic               opush;
    logic               opop;
    res_t               res_in;

    logic               take;
    logic               cread;
    logic [COSET_W-1:0] caddr;
    logic               mread;
    logic [ELEM_W-1:0]  maddr;
    logic               last;

    assign ofull  = (ocnt_reg == (QPTR_W+1)'(QDEPTH));
    assign empty  = (ocnt_reg == '0);
    assign opop   = pop && !empty;
    assign result = ofifo[orp_reg];

    assign take  = (state_reg == K_IDLE) && !q_empty && !ofull;
    assign q_pop = take;
    assign cread = take;
    assign caddr = (cmd.kind == CMD_LIST) ? cmd.cidx : cmd.owner;
    assign last  = (j_reg + POS_W'(1) == clen_reg);

    always_comb
    begin
        mread  = 1'b0;
        maddr  = first_rd;
        opush  = 1'b0;
        res_in = '0;
        unique case (state_reg)
            K_IDLE:
            begin
                if (take && cmd.kind == CMD_ERR_CAP)
                begin
                    opush              = 1'b1;
                    res_in.last_member = 1'b1;
                    res_in.status      = STATUS_CAP;
                end
                else if (take && cmd.kind == CMD_ERR_RANGE)
                begin
                    opush              = 1'b1;
                    res_in.coset_total = stat.total;
                    res_in.last_member = 1'b1;
                    res_in.status      = STATUS_RANGE;
                end
            end
            K_LEN:
            begin
                opush                  = !ofull;
                res_in.coset_id        = cmd_reg.owner;
                res_in.member_value    = cmd_reg.elem;
                res_in.member_position = cmd_reg.pos;
                res_in.coset_length    = len_rd;
                res_in.coset_total     = stat.total;
                res_in.last_member     = 1'b1;
                res_in.status          = STATUS_OK;
            end
            K_HEAD:
            begin
                mread = 1'b1;
                maddr = first_rd;
            end
            K_EMIT:
            begin
                opush                  = !ofull;
                res_in.coset_id        = cmd_reg.cidx;
                res_in.member_value    = member_rd;
                res_in.member_position = j_reg;
                res_in.coset_length    = clen_reg;
                res_in.coset_total     = stat.total;
                res_in.last_member     = last;
                res_in.status          = STATUS_OK;
                // fetch the next member only once this one is taken
                mread = !ofull && !last;
                maddr = first_reg + ELEM_W'(j_reg) + ELEM_W'(1);
            end
            default:
            begin
                opush = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr.head_we)
        begin
            first_mem[wr.head_addr] <= wr.head_first;
        end
        if (wr.len_we)
        begin
            len_mem[wr.len_addr] <= wr.len_val;
        end
        if (wr.mem_we)
        begin
            member_mem[wr.mem_addr] <= wr.mem_val;
        end
        if (cread)
        begin
            first_rd <= first_mem[cmd.cidx];
            len_rd   <= len_mem[caddr];
        end
        if (mread)
        begin
            member_rd <= member_mem[maddr];
        end
        if (opush)
        begin
            ofifo[owp_reg] <= res_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= K_IDLE;
            owp_reg   <= '0;
            orp_reg   <= '0;
            ocnt_reg  <= '0;
            j_reg     <= '0;
        end
        else
        begin
            if (opush)
            begin
                owp_reg <= owp_reg + QPTR_W'(1);
            end
            if (opop)
            begin
                orp_reg <= orp_reg + QPTR_W'(1);
            end
            ocnt_reg <= ocnt_reg + (QPTR_W+1)'(opush) - (QPTR_W+1)'(opop);

            unique case (state_reg)
                K_IDLE:
                begin
                    if (take && cmd.kind == CMD_LOOKUP)
                    begin
                        state_reg <= K_LEN;
                    end
                    else if (take && cmd.kind == CMD_LIST)
                    begin
                        state_reg <= K_HEAD;
                    end
                end
                K_LEN:
                begin
                    if (!ofull)
                    begin
                        state_reg <= K_IDLE;
                    end
                end
                K_HEAD:
                begin
                    j_reg     <= '0;
                    state_reg <= K_EMIT;
                end
                K_EMIT:
                begin
                    if (!ofull)
                    begin
                        j_reg <= j_reg + POS_W'(1);
                        if (last)
                        begin
                            state_reg <= K_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= K_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cmd_reg <= cmd;
        end
        if (state_reg == K_HEAD)
        begin
            first_reg <= first_rd;
            clen_reg  <= len_rd;
        end
    end

endmodule

// ===== rtl/cyclotomic_coset_partition_top.sv =====
// top level of the cyclotomic coset partition block: config registers and wiring
// depends on ccp_pkg, ccp_builder, ccp_front, ccp_queue, ccp_back
//
// channel   handshake            payload     direction
// item      push / full          in_item_t   in
// result    pop / empty          res_t       out
// config    psel penable pwrite  pwdata      in (APB, pready tied high)
//
// a lookup in the back end reads the length, then emits one result beat
// a listing reads head and length, then one member read a cycle while the output queue has room
// after reset or any register write the block rebuilds: it clears the used map,
// forms the modulus, then walks each coset element by element;
// full stays high throughout
// results are held in a two-beat output queue; a stalled pop stops the back end,
// then the command queue fills and full rises
module cyclotomic_coset_partition_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               push,
    output logic               full,
    input  ccp_pkg::in_item_t  item,
    output logic               empty,
    input  logic               pop,
    output ccp_pkg::res_t      result
);
    import ccp_pkg::*;

    logic [BASE_W-1:0] base_reg;
    logic [DEG_W-1:0]  degree_reg;
    logic              cfg_we;
    tbl_wr_t           wr;
    bld_stat_t         stat;
    cmd_t              cmd_in;
    cmd_t              cmd_out;
    logic              q_push;
    logic              q_pop;
    logic              q_full;
    logic              q_empty;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg   <= BASE_W'(2);
            degree_reg <= DEG_W'(4);
        end
        else if (cfg_we)
        begin
            unique case (paddr[2])
                REG_FIELD_BASE: base_reg   <= pwdata[BASE_W-1:0];
                REG_EXT_DEGREE: degree_reg <= pwdata[DEG_W-1:0];
                default:        base_reg   <= base_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_FIELD_BASE: prdata = 32'(base_reg);
            REG_EXT_DEGREE: prdata = 32'(degree_reg);
            default:        prdata = '0;
        endcase
    end

    ccp_builder u_builder (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cfg_we),
        .base   (base_reg),
        .degree (degree_reg),
        .wr     (wr),
        .stat   (stat)
    );

    ccp_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .stat   (stat),
        .wr     (wr),
        .q_full (q_full),
        .q_push (q_push),
        .cmd    (cmd_in)
    );

    ccp_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (cmd_in),
        .full  (q_full),
        .pop   (q_pop),
        .dout  (cmd_out),
        .empty (q_empty)
    );

    ccp_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd_out),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .wr      (wr),
        .stat    (stat),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

`ifndef SYNTH
    a_busy_full: assert property (@(posedge clk) disable iff (!rst_n)
        stat.busy |-> full)
        else $error("item accepted while partition is rebuilding");

    a_cfg_rebuild: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> (stat.busy && stat.total == '0))
        else $error("register write did not restart the build");

    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.status != STATUS_OK) |-> result.last_member)
        else $error("error beat without last mark");
`endif

endmodule
